### sv/ctc_pkg.sv
// ctc_pkg: payload structs, calendar constants and the month length table
// for the calendar tick clock. No dependencies.
package ctc_pkg;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
    localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
    localparam logic [4:0] HOURS_PER_DAY      = 5'd24;
    localparam logic [3:0] MONTHS_END         = 4'd13;
    localparam logic [3:0] MONTH_FIRST        = 4'd1;

    localparam logic [4:0] DAYS_SHORT = 5'd28;
    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_MID   = 5'd30;

    localparam logic [7:0] SAVE_INTERVAL_RESET = 8'd100;

    typedef struct packed {
        logic        op;
        logic [6:0]  load_centisecond;
        logic [5:0]  load_second;
        logic [5:0]  load_minute;
        logic [4:0]  load_hour;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [15:0] load_year;
    } ctc_in_t;

    typedef struct packed {
        logic [6:0]  centisecond;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic        save_now;
    } ctc_out_t;

    // calendar counters above the sub-second counter
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } ctc_cal_t;

    // no leap years; any code outside 1..12 counts as a 30-day month
    function automatic logic [4:0] month_length(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:   len = DAYS_SHORT;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAYS_LONG;
            default: len = DAYS_MID;
        endcase
        return len;
    endfunction

endpackage

### sv/calendar_tick_clock.sv
// calendar_tick_clock: top level of the tick-driven calendar clock.
// Depends on ctc_pkg and ctc_advance.
//
//  channel  | ports                         | payload
//  ---------+-------------------------------+-----------------------------
//  input    | s_valid, s_ready, s_data      | ctc_in_t  (tick or load)
//  result   | m_valid, m_ready, m_data      | ctc_out_t (time, save strobe)
//  config   | cfg_wr_en, cfg_wr_data        | save_interval, 8 bits
//
// One transaction per cycle sustained while m_ready holds; each result is held in
// the single result register and appears in the cycle after its input transaction.
// The input side accepts whenever the result register is empty or being
// drained in the same cycle, so a stalled result holds only one transaction.
// Reset (aresetn low, synchronous) sets the time to day 0 of month 1 of year
// 0, the save interval and countdown to 100, and empties the result register.
module calendar_tick_clock #(
    parameter int TICKS_PER_SECOND = 100
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ctc_pkg::ctc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ctc_pkg::ctc_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data
);
    import ctc_pkg::*;

    // hold at least the 7-bit load field, more when a second has more ticks
    localparam int CENTI_W = (TICKS_PER_SECOND > 128) ? $clog2(TICKS_PER_SECOND) : 7;
    localparam logic [CENTI_W-1:0] CENTI_LAST = CENTI_W'(TICKS_PER_SECOND - 1);

    logic [CENTI_W-1:0] centi_reg, centi_next;
    ctc_cal_t           cal_reg, cal_next, cal_adv;
    logic [7:0]         countdown_reg, countdown_next;
    logic [7:0]         interval_reg;
    logic               m_valid_reg;
    ctc_out_t           m_data_reg, m_data_next;

    logic               accept;
    logic               centi_carry;
    logic [7:0]         countdown_dec;
    logic               save_hit;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // sub-second counter carries at or above its last value, so a bad load recovers
    assign centi_carry   = !(centi_reg < CENTI_LAST);
    assign countdown_dec = countdown_reg - 8'd1;
    assign save_hit      = (countdown_dec == 8'd0);

    ctc_advance u_advance (
        .carry_in (centi_carry),
        .cal_cur  (cal_reg),
        .cal_nxt  (cal_adv)
    );

    always_comb begin
        centi_next     = centi_reg;
        cal_next       = cal_reg;
        countdown_next = countdown_reg;
        if (s_data.op == OP_LOAD) begin
            // load every calendar counter; leave the save countdown alone
            centi_next     = CENTI_W'(s_data.load_centisecond);
            cal_next.second = s_data.load_second;
            cal_next.minute = s_data.load_minute;
            cal_next.hour   = s_data.load_hour;
            cal_next.day    = s_data.load_day;
            cal_next.month  = s_data.load_month;
            cal_next.year   = s_data.load_year;
        end else begin
            centi_next     = centi_carry ? '0 : centi_reg + CENTI_W'(1);
            cal_next       = cal_adv;
            countdown_next = save_hit ? interval_reg : countdown_dec;
        end
        m_data_next.centisecond = centi_next[6:0];
        m_data_next.second      = cal_next.second;
        m_data_next.minute      = cal_next.minute;
        m_data_next.hour        = cal_next.hour;
        m_data_next.day         = cal_next.day;
        m_data_next.month       = cal_next.month;
        m_data_next.year        = cal_next.year;
        m_data_next.save_now    = (s_data.op == OP_TICK) && save_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centi_reg     <= '0;
            cal_reg       <= '{second: '0, minute: '0, hour: '0, day: '0,
                               month: MONTH_FIRST, year: '0};
            countdown_reg <= SAVE_INTERVAL_RESET;
            interval_reg  <= SAVE_INTERVAL_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                interval_reg <= cfg_wr_data;
            end
            if (accept) begin
                centi_reg     <= centi_next;
                cal_reg       <= cal_next;
                countdown_reg <= countdown_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // a load never raises the save strobe
    a_load_no_save: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.op == OP_LOAD |=> !m_data.save_now)
        else $error("save strobe on a load transaction");

    // a load shows the loaded year in its result
    a_load_year: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.op == OP_LOAD |=> m_data.year == $past(s_data.load_year))
        else $error("loaded year not reflected in result");

    // countdown expiry reloads from the interval and strobes
    a_save_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.op == OP_TICK && countdown_reg == 8'd1
        |=> countdown_reg == $past(interval_reg) && m_data.save_now)
        else $error("save countdown did not reload on expiry");

    // input stalls only behind a result that is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a pending result");

endmodule

### sv/ctc_advance.sv
// ctc_advance: combinational carry cascade from seconds through year.
// Depends on ctc_pkg.
module ctc_advance (
    input  logic               carry_in,
    input  ctc_pkg::ctc_cal_t  cal_cur,
    output ctc_pkg::ctc_cal_t  cal_nxt
);
    import ctc_pkg::*;

    logic [5:0]  sec_inc;
    logic [5:0]  min_inc;
    logic [4:0]  hour_inc;
    logic [4:0]  day_inc;
    logic [3:0]  month_inc;

    always_comb begin
        sec_inc   = cal_cur.second + 6'd1;
        min_inc   = cal_cur.minute + 6'd1;
        hour_inc  = cal_cur.hour + 5'd1;
        day_inc   = cal_cur.day + 5'd1;
        month_inc = cal_cur.month + 4'd1;
        cal_nxt   = cal_cur;
        if (carry_in) begin
            cal_nxt.second = sec_inc;
            if (sec_inc >= SECONDS_PER_MINUTE) begin
                cal_nxt.second = '0;
                cal_nxt.minute = min_inc;
                if (min_inc >= MINUTES_PER_HOUR) begin
                    cal_nxt.minute = '0;
                    cal_nxt.hour   = hour_inc;
                    if (hour_inc >= HOURS_PER_DAY) begin
                        cal_nxt.hour = '0;
                        cal_nxt.day  = day_inc;
                        if (day_inc >= month_length(cal_cur.month)) begin
                            cal_nxt.day   = '0;
                            cal_nxt.month = month_inc;
                            // past December, or wrapped to zero from 15
                            if (month_inc >= MONTHS_END || month_inc == 4'd0) begin
                                cal_nxt.month = MONTH_FIRST;
                                cal_nxt.year  = cal_cur.year + 16'd1;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

### tb/calendar_tick_clock_test.sv
// calendar_tick_clock_test: self-checking bench for the tick-driven calendar clock.
// Depends on ctc_pkg and calendar_tick_clock; keeps its own copy of the calendar
// and save countdown and checks every result transaction against it.
module calendar_tick_clock_test;
    import ctc_pkg::*;

    localparam int          TICKS_PER_SECOND = 100;
    localparam logic [3:0]  FEBRUARY         = 4'd2;
    // one bit per month code that has 31 days: 1, 3, 5, 7, 8, 10, 12
    localparam logic [15:0] LONG_MONTHS      = 16'h15AA;

    // Shadow calendar: advance on each accepted input transaction, queue the
    // time the block should report, and check result transactions in order.
    class wall_clock;
        logic [6:0]  centi;
        logic [5:0]  sec;
        logic [5:0]  mins;
        logic [4:0]  hr;
        logic [4:0]  dom;
        logic [3:0]  mon;
        logic [15:0] yr;
        logic [7:0]  interval;
        logic [7:0]  countdown;
        ctc_out_t    due_times[$];
        int          errors;

        function new();
            centi     = '0;
            sec       = '0;
            mins      = '0;
            hr        = '0;
            dom       = '0;
            mon       = MONTH_FIRST;
            yr        = '0;
            interval  = SAVE_INTERVAL_RESET;
            countdown = SAVE_INTERVAL_RESET;
            errors    = 0;
        endfunction

        static function logic [4:0] days_in(logic [3:0] m);
            if (m == FEBRUARY) return DAYS_SHORT;
            if (LONG_MONTHS[m]) return DAYS_LONG;
            return DAYS_MID;
        endfunction

        function void set_interval(logic [7:0] v);
            interval = v;
        endfunction

        function void roll_day();
            dom = dom + 5'd1;
            if (dom >= days_in(mon)) begin
                dom = '0;
                mon = mon + 4'd1;
                if (mon >= MONTHS_END || mon == 4'd0) begin
                    mon = MONTH_FIRST;
                    yr  = yr + 16'd1;
                end
            end
        endfunction

        function void accept_command(ctc_in_t c);
            ctc_out_t r;
            logic     strobe;
            strobe = 1'b0;
            if (c.op == OP_LOAD) begin
                centi = c.load_centisecond;
                sec   = c.load_second;
                mins  = c.load_minute;
                hr    = c.load_hour;
                dom   = c.load_day;
                mon   = c.load_month;
                yr    = c.load_year;
            end else begin
                // every carry test is greater-or-equal so bad loads recover
                if (int'(centi) < TICKS_PER_SECOND - 1) begin
                    centi = centi + 7'd1;
                end else begin
                    centi = '0;
                    sec   = sec + 6'd1;
                    if (sec >= SECONDS_PER_MINUTE) begin
                        sec  = '0;
                        mins = mins + 6'd1;
                        if (mins >= MINUTES_PER_HOUR) begin
                            mins = '0;
                            hr   = hr + 5'd1;
                            if (hr >= HOURS_PER_DAY) begin
                                hr = '0;
                                roll_day();
                            end
                        end
                    end
                end
                // an interval of zero reloads zero, which wraps to 255 next tick
                countdown = countdown - 8'd1;
                if (countdown == 8'd0) begin
                    countdown = interval;
                    strobe    = 1'b1;
                end
            end
            r.centisecond = centi;
            r.second      = sec;
            r.minute      = mins;
            r.hour        = hr;
            r.day         = dom;
            r.month       = mon;
            r.year        = yr;
            r.save_now    = strobe;
            due_times.push_back(r);
        endfunction

        function void compare_time(ctc_out_t got);
            ctc_out_t want;
            if (due_times.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result transaction with nothing outstanding: %h", got);
                return;
            end
            want = due_times.pop_front();
            if (got.centisecond !== want.centisecond || got.second !== want.second ||
                got.minute !== want.minute || got.hour !== want.hour ||
                got.day !== want.day || got.month !== want.month ||
                got.year !== want.year || got.save_now !== want.save_now) begin
                errors++;
                if (errors <= 10) begin
                    $display("time mismatch: expected %0d:%0d:%0d.%0d day %0d month %0d year %0d save %0b",
                             want.hour, want.minute, want.second, want.centisecond,
                             want.day, want.month, want.year, want.save_now);
                    $display("               got      %0d:%0d:%0d.%0d day %0d month %0d year %0d save %0b",
                             got.hour, got.minute, got.second, got.centisecond,
                             got.day, got.month, got.year, got.save_now);
                end
            end
        endfunction
    endclass

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    ctc_in_t    s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    ctc_out_t   m_data;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    wall_clock clock_copy = new();

    // chance of an idle burst is 1 in N per decision; zero turns idling off
    int gap_odds   = 0;
    int ready_odds = 0;

    calendar_tick_clock #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case the block hangs a handshake.
    initial begin
        #3000000;
        $display("calendar_tick_clock_test: errors");
        $finish;
    end

    // Result side: stall in random bursts, otherwise hold ready high.
    initial begin
        forever begin
            @(posedge aclk);
            if (ready_odds != 0 && $urandom_range(1, ready_odds) == 1) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Sample at the edge: signals still hold their pre-edge values here.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            clock_copy.compare_time(m_data);
    end

    // Present one transaction and hold it until the block takes it.
    task automatic push_item(ctc_in_t item);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        clock_copy.accept_command(item);
    endtask

    task automatic maybe_idle();
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // Drain every outstanding result, then write the save interval.
    task automatic write_interval(logic [7:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (clock_copy.due_times.size() != 0) @(posedge aclk);
        @(posedge aclk);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        clock_copy.set_interval(v);
    endtask

    function automatic ctc_in_t make_load(int c, int s, int mi, int h, int d, int mo, int y);
        ctc_in_t item;
        item.op               = OP_LOAD;
        item.load_centisecond = 7'(c);
        item.load_second      = 6'(s);
        item.load_minute      = 6'(mi);
        item.load_hour        = 5'(h);
        item.load_day         = 5'(d);
        item.load_month       = 4'(mo);
        item.load_year        = 16'(y);
        return item;
    endfunction

    // Tick with junk in the load fields; the block must ignore them.
    function automatic ctc_in_t random_tick();
        ctc_in_t     item;
        logic [63:0] raw;
        raw     = {$urandom, $urandom};
        item    = raw[$bits(ctc_in_t)-1:0];
        item.op = OP_TICK;
        return item;
    endfunction

    // Mostly legal times parked just before a carry, sometimes raw bits.
    function automatic ctc_in_t random_load();
        ctc_in_t     item;
        logic [63:0] raw;
        raw     = {$urandom, $urandom};
        item    = raw[$bits(ctc_in_t)-1:0];
        item.op = OP_LOAD;
        if ($urandom_range(0, 9) != 0) begin
            item.load_centisecond = $urandom_range(0, 1) ?
                7'(TICKS_PER_SECOND - 1 - $urandom_range(0, 3)) :
                7'($urandom_range(0, TICKS_PER_SECOND - 1));
            item.load_second = $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59));
            item.load_minute = $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59));
            item.load_hour   = $urandom_range(0, 1) ? 5'd23 : 5'($urandom_range(0, 23));
            item.load_month  = 4'($urandom_range(1, 12));
            item.load_day    = $urandom_range(0, 1) ?
                wall_clock::days_in(item.load_month) - 5'd1 :
                5'($urandom_range(0, 27));
            item.load_year   = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
        return item;
    endfunction

    task automatic run_phase(int count);
        repeat (count) begin
            maybe_idle();
            if ($urandom_range(0, 9) == 0)
                push_item(random_load());
            else
                push_item(random_tick());
        end
    endtask

    initial begin
        int waited;

        // Hold reset low at the start, then release it once.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_odds   = 4;
        ready_odds = 4;

        // Directed: first tick from reset, then loads parked on each carry.
        push_item(random_tick());
        push_item(make_load(0, 0, 0, 0, 0, 1, 0));
        push_item(random_tick());
        // full rollover on the last day of December wraps the year
        push_item(make_load(99, 59, 59, 23, 30, 12, 65535));
        push_item(random_tick());
        // end of February
        push_item(make_load(99, 59, 59, 23, 27, 2, 7));
        push_item(random_tick());
        // end of a 30-day month
        push_item(make_load(99, 59, 59, 23, 29, 4, 7));
        push_item(random_tick());
        // month code zero counts as 30 days and moves to January
        push_item(make_load(99, 59, 59, 23, 29, 0, 7));
        push_item(random_tick());
        // month code 15 wraps to zero, then to January of the next year
        push_item(make_load(99, 59, 59, 23, 29, 15, 7));
        push_item(random_tick());
        push_item(make_load(99, 59, 59, 23, 29, 13, 7));
        push_item(random_tick());
        // every load bit high: counters out of range recover at the next carry
        push_item(make_load(127, 63, 63, 31, 31, 15, 65535));
        push_item(random_tick());
        // second beyond 59 and a day beyond February's length
        push_item(make_load(99, 60, 59, 23, 30, 2, 7));
        push_item(random_tick());
        // hour beyond 23
        push_item(make_load(99, 59, 59, 24, 5, 6, 7));
        push_item(random_tick());
        push_item(make_load(98, 59, 59, 23, 30, 12, 65535));
        push_item(random_tick());
        push_item(random_tick());

        run_phase(60);

        // Walk the save interval through its extremes between phases.
        write_interval(8'd1);
        run_phase(80);

        gap_odds   = 0;
        ready_odds = 6;
        write_interval(8'd255);
        run_phase(60);

        // interval zero: a strobe only every 256 ticks, so run this one long
        gap_odds   = 3;
        ready_odds = 3;
        write_interval(8'd0);
        run_phase(280);

        gap_odds   = 8;
        ready_odds = 0;
        write_interval(8'($urandom_range(2, 254)));
        run_phase(40);

        // Tail: no idling on either side.
        gap_odds   = 0;
        ready_odds = 0;
        write_interval(SAVE_INTERVAL_RESET);
        run_phase(30);

        s_valid <= 1'b0;
        waited = 0;
        while (clock_copy.due_times.size() != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);

        if (clock_copy.errors == 0 && clock_copy.due_times.size() == 0) begin
            $display("calendar_tick_clock_test: clean");
        end else begin
            $display("calendar_tick_clock_test: errors");
        end
        $finish;
    end

endmodule
